// ===== hw/rtl/palette_nearest_color_search_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the palette nearest color search block
// Shorthand for clocked assertions on i_clk, disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef PALETTE_NEAREST_COLOR_SEARCH_MACROS_SVH
`define PALETTE_NEAREST_COLOR_SEARCH_MACROS_SVH

// Check a consequence in the same cycle as the antecedent
`define PNCS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after the antecedent
`define PNCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/pncs_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pncs_pkg
// Shared widths, types and the default palette table for the nearest color
// search block.
// ---------------------------------------------------------------------------
package pncs_pkg;

    localparam int INDEX_W             = 8;
    localparam int COLOR_W             = 8;
    localparam int ENTRY_W             = 3 * COLOR_W;
    localparam int DIST_W              = 18;
    localparam int BEST_W              = DIST_W + 1;
    localparam int COUNT_W             = 32;
    localparam int MAX_ENTRIES         = 256;
    localparam int PALETTE_ENTRIES_DEF = 256;

    // Start value of the running minimum: above any real distance
    localparam logic [BEST_W-1:0] BEST_INIT = BEST_W'(256 * 256 * 4);

    // Tag that travels with each entry through the scan pipeline
    typedef struct packed {
        logic               valid;
        logic               last;
        logic [INDEX_W-1:0] index;
    } t_scan_tag;

    typedef logic [MAX_ENTRIES-1:0][ENTRY_W-1:0] t_palette_rom;

    // Build the power-up palette: text colors, blue, red and grey ramps,
    // then the leading part of a six-level color cube
    function automatic t_palette_rom build_default_palette();
        t_palette_rom rom;
        int           ri;
        int           gi;
        int           bi;
        rom     = '0;
        rom[0]  = 24'h000000;
        rom[1]  = 24'h0000AA;
        rom[2]  = 24'h00AA00;
        rom[3]  = 24'h00AAAA;
        rom[4]  = 24'hAA0000;
        rom[5]  = 24'hAA00AA;
        rom[6]  = 24'hAA5500;
        rom[7]  = 24'hAAAAAA;
        rom[8]  = 24'h555555;
        rom[9]  = 24'h5555FF;
        rom[10] = 24'h55FF55;
        rom[11] = 24'h55FFFF;
        rom[12] = 24'hFF5555;
        rom[13] = 24'hFF55FF;
        rom[14] = 24'hFFFF55;
        rom[15] = 24'hFFFFFF;
        for (int n = 0; n < 16; n++) begin
            rom[16 + n] = {16'h0000, COLOR_W'(16 + n * 14)};
            rom[32 + n] = {COLOR_W'(16 + n * 14), 16'h0000};
            rom[48 + n] = {3{COLOR_W'(n * 16 + 8)}};
        end
        ri = 0;
        gi = 0;
        bi = 0;
        for (int n = 64; n < MAX_ENTRIES; n++) begin
            rom[n] = {COLOR_W'(ri * 51), COLOR_W'(gi * 51), COLOR_W'(bi * 51)};
            bi++;
            if (bi == 6) begin
                bi = 0;
                gi++;
                if (gi == 6) begin
                    gi = 0;
                    ri++;
                end
            end
        end
        return rom;
    endfunction

    localparam t_palette_rom DEFAULT_PALETTE = build_default_palette();

endpackage

// ===== hw/rtl/pncs_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pncs_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module pncs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/pncs_dist.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pncs_dist
// Shared distance unit: squared RGB distance of one palette entry to the
// query color per cycle, registered together with the entry's scan tag.
// ---------------------------------------------------------------------------
module pncs_dist (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [pncs_pkg::ENTRY_W-1:0]      i_query_rgb,
    input  logic [pncs_pkg::ENTRY_W-1:0]      i_entry_rgb,
    input  pncs_pkg::t_scan_tag               i_tag,
    output logic [pncs_pkg::DIST_W-1:0]       o_dist,
    output pncs_pkg::t_scan_tag               o_tag
);

    localparam int CW = pncs_pkg::COLOR_W;
    localparam int SW = 2 * CW;

    logic [CW-1:0]               w_dr;
    logic [CW-1:0]               w_dg;
    logic [CW-1:0]               w_db;
    logic [SW-1:0]               w_sr;
    logic [SW-1:0]               w_sg;
    logic [SW-1:0]               w_sb;
    logic [pncs_pkg::DIST_W-1:0] w_sum;
    logic [pncs_pkg::DIST_W-1:0] r_dist;
    pncs_pkg::t_scan_tag         r_tag;

    // Absolute component differences
    always_comb begin
        w_dr = (i_query_rgb[3*CW-1:2*CW] > i_entry_rgb[3*CW-1:2*CW])
             ? i_query_rgb[3*CW-1:2*CW] - i_entry_rgb[3*CW-1:2*CW]
             : i_entry_rgb[3*CW-1:2*CW] - i_query_rgb[3*CW-1:2*CW];
        w_dg = (i_query_rgb[2*CW-1:CW] > i_entry_rgb[2*CW-1:CW])
             ? i_query_rgb[2*CW-1:CW] - i_entry_rgb[2*CW-1:CW]
             : i_entry_rgb[2*CW-1:CW] - i_query_rgb[2*CW-1:CW];
        w_db = (i_query_rgb[CW-1:0] > i_entry_rgb[CW-1:0])
             ? i_query_rgb[CW-1:0] - i_entry_rgb[CW-1:0]
             : i_entry_rgb[CW-1:0] - i_query_rgb[CW-1:0];
    end

    // Square and sum
    always_comb begin
        w_sr  = SW'(w_dr) * SW'(w_dr);
        w_sg  = SW'(w_dg) * SW'(w_dg);
        w_sb  = SW'(w_db) * SW'(w_db);
        w_sum = pncs_pkg::DIST_W'(w_sr) + pncs_pkg::DIST_W'(w_sg)
              + pncs_pkg::DIST_W'(w_sb);
    end

    // Register the tag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else begin
            r_tag <= i_tag;
        end
    end

    // Register the distance
    always_ff @(posedge i_clk) begin
        r_dist <= w_sum;
    end

    assign o_dist = r_dist;
    assign o_tag  = r_tag;

endmodule

// ===== hw/rtl/palette_nearest_color_search.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// palette_nearest_color_search
// RGB palette with a change counter; writes store one entry, lookups scan
// the whole palette for the entry with the least squared RGB distance.
// ---------------------------------------------------------------------------
//  Channel   Dir  Fields (tdata low bit up)                   tuser
//  s_axis    in   entry_index, red, green, blue (32 bits)     func
//  m_axis    out  nearest_index, nearest_distance,            -
//                 change_count, zero pad (64 bits)
//
//  A write's result is loaded at the accept edge.
//  During a lookup one palette entry per cycle passes through the RAM read
//  and the shared distance unit.
//  Input is taken only while the sequencer is idle and the result register
//  is empty or being emptied.
//  Reset puts the power-up palette in place at once through per-entry valid
//  bits; no clearing pass is needed.
// ---------------------------------------------------------------------------
`include "palette_nearest_color_search_macros.svh"

module palette_nearest_color_search #(
    parameter int PALETTE_ENTRIES = pncs_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // entry_index, red, green, blue
    input  logic [0:0]  s_axis_tuser,   // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // nearest_index, nearest_distance,
                                        // change_count, zero pad
);

    localparam int ADDR_W  = $clog2(PALETTE_ENTRIES);
    localparam int IW      = pncs_pkg::INDEX_W;
    localparam int CW      = pncs_pkg::COLOR_W;
    localparam int EW      = pncs_pkg::ENTRY_W;
    localparam int DW      = pncs_pkg::DIST_W;
    localparam int BW      = pncs_pkg::BEST_W;
    localparam int NW      = pncs_pkg::COUNT_W;
    localparam int PAD_W   = 64 - (IW + DW + NW);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PALETTE_ENTRIES - 1);
    localparam logic [IW:0]       ENTRY_LIM = (IW + 1)'(PALETTE_ENTRIES);

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    // Input unpacking
    logic [IW-1:0] w_in_index;
    logic [EW-1:0] w_in_rgb;
    logic          w_func;
    logic          w_accept;
    logic          w_wr_hit;
    logic          w_out_free;

    // Control state
    logic [1:0]               r_state;
    logic [1:0]               n_state;
    logic                     r_m_valid;
    logic                     n_m_valid;
    logic [NW-1:0]            r_count;
    logic [NW-1:0]            n_count;
    logic [PALETTE_ENTRIES-1:0] r_valid;

    // Scan datapath
    logic [ADDR_W-1:0]   r_addr;
    logic [ADDR_W-1:0]   n_addr;
    logic [EW-1:0]       r_query;
    pncs_pkg::t_scan_tag r_p1;
    logic                r_p1_vld;
    logic [EW-1:0]       r_p1_def;
    logic [EW-1:0]       w_ram_q;
    logic [EW-1:0]       w_entry;
    logic [DW-1:0]       w_dist;
    pncs_pkg::t_scan_tag w_tag2;
    logic                w_better;
    logic [BW-1:0]       r_best_d;
    logic [BW-1:0]       n_best_d;
    logic [IW-1:0]       r_best_idx;
    logic [IW-1:0]       n_best_idx;

    // Result register
    logic [IW-1:0] r_out_index;
    logic [IW-1:0] n_out_index;
    logic [DW-1:0] r_out_dist;
    logic [DW-1:0] n_out_dist;
    logic [NW-1:0] r_out_count;
    logic [NW-1:0] n_out_count;

    assign w_in_index = s_axis_tdata[IW-1:0];
    assign w_in_rgb   = {s_axis_tdata[IW+CW-1:IW], s_axis_tdata[IW+2*CW-1:IW+CW],
                         s_axis_tdata[IW+3*CW-1:IW+2*CW]};
    assign w_func     = s_axis_tuser[0];

    // Handshake
    assign w_out_free    = !r_m_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE) && w_out_free;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_wr_hit      = w_accept && (w_func == FUNC_WRITE)
                         && ({1'b0, w_in_index} < ENTRY_LIM);

    // Palette storage
    pncs_ram #(
        .WIDTH (EW),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (w_wr_hit),
        .i_waddr (ADDR_W'(w_in_index)),
        .i_wdata (w_in_rgb),
        .i_raddr (r_addr),
        .o_rdata (w_ram_q)
    );

    // Read stage: tag, written flag and power-up value beside the RAM read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1 <= '0;
        end else begin
            r_p1.valid <= (r_state == ST_SCAN);
            r_p1.last  <= (r_addr == LAST_ADDR);
            r_p1.index <= IW'(r_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_vld <= r_valid[r_addr];
        r_p1_def <= pncs_pkg::DEFAULT_PALETTE[IW'(r_addr)];
    end

    // Unwritten entries read as their power-up color
    assign w_entry = r_p1_vld ? w_ram_q : r_p1_def;

    pncs_dist u_dist (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_query_rgb (r_query),
        .i_entry_rgb (w_entry),
        .i_tag       (r_p1),
        .o_dist      (w_dist),
        .o_tag       (w_tag2)
    );

    // Strictly smaller keeps the lowest index on ties
    assign w_better = w_tag2.valid && ({1'b0, w_dist} < r_best_d);

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_m_valid   = r_m_valid;
        n_count     = r_count;
        n_addr      = r_addr;
        n_best_d    = r_best_d;
        n_best_idx  = r_best_idx;
        n_out_index = r_out_index;
        n_out_dist  = r_out_dist;
        n_out_count = r_out_count;

        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (w_func == FUNC_WRITE) begin
                        if (w_wr_hit) begin
                            n_count = r_count + 1'b1;
                        end
                        n_m_valid   = 1'b1;
                        n_out_index = '0;
                        n_out_dist  = '0;
                        n_out_count = n_count;
                    end else begin
                        n_state    = ST_SCAN;
                        n_addr     = '0;
                        n_best_d   = pncs_pkg::BEST_INIT;
                        n_best_idx = '0;
                    end
                end
            end
            ST_SCAN: begin
                if (r_addr == LAST_ADDR) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (w_tag2.valid && w_tag2.last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    n_m_valid   = 1'b1;
                    n_out_index = r_best_idx;
                    n_out_dist  = DW'(r_best_d);
                    n_out_count = r_count;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Track the running minimum
        if (w_better) begin
            n_best_d   = {1'b0, w_dist};
            n_best_idx = w_tag2.index;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
            r_count   <= '0;
            r_valid   <= '0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
            r_count   <= n_count;
            if (w_wr_hit) begin
                r_valid[ADDR_W'(w_in_index)] <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_best_d    <= n_best_d;
        r_best_idx  <= n_best_idx;
        r_out_index <= n_out_index;
        r_out_dist  <= n_out_dist;
        r_out_count <= n_out_count;
        if (w_accept) begin
            r_query <= w_in_rgb;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_out_count, r_out_dist, r_out_index};

    // Checks
    `PNCS_ASSERT_NEXT(a_count_on_write, w_wr_hit, r_count == $past(r_count) + 32'd1, "counter did not advance on a stored write")
    `PNCS_ASSERT_NEXT(a_scan_start, w_accept && (w_func == FUNC_LOOKUP), (r_state == ST_SCAN) && (r_addr == '0), "lookup did not start scan at entry zero")
    `PNCS_ASSERT_SAME(a_tag_in_scan, w_tag2.valid, (r_state == ST_SCAN) || (r_state == ST_DRAIN), "distance result outside a scan")
    `PNCS_ASSERT_NEXT(a_finish_load, (r_state == ST_FINISH) && w_out_free, m_axis_tvalid && (r_state == ST_IDLE), "lookup result not loaded")

endmodule

// ===== test/palette_match_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// palette_match_checker
// Watches both stream channels of the nearest color search block, keeps a
// shadow palette and change counter, predicts each result and compares it
// field by field with what the block returns.
// ---------------------------------------------------------------------------

// Request kinds carried in s_axis_tuser, shared by checker and stimulus
package palette_tb_pkg;

    typedef enum logic [0:0] {
        FUNC_WRITE  = 1'b0,
        FUNC_LOOKUP = 1'b1
    } t_pncs_func;

endpackage

module palette_match_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,   // entry_index, red, green, blue
    input  logic [0:0]  i_s_tuser,   // func
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [63:0] i_m_tdata,   // nearest_index, nearest_distance,
                                     // change_count, zero pad
    output int          o_fail_count,
    output int          o_pending
);

    localparam int ENTRIES_IN_USE = pncs_pkg::PALETTE_ENTRIES_DEF;

    typedef struct packed {
        logic [pncs_pkg::INDEX_W-1:0] index;
        logic [pncs_pkg::DIST_W-1:0]  distance;
        logic [pncs_pkg::COUNT_W-1:0] count;
    } t_color_match;

    logic [pncs_pkg::ENTRY_W-1:0] palette_shadow [pncs_pkg::MAX_ENTRIES];
    logic [pncs_pkg::COUNT_W-1:0] change_total;
    t_color_match                 expected_matches [$];
    int                           fail_total = 0;
    int                           pending_total = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_total;

    // Power-up color of one palette slot, as {red, green, blue}
    function automatic logic [pncs_pkg::ENTRY_W-1:0] power_up_color(input int n);
        int k;
        if (n < 16) begin
            case (n)
                0:       return 24'h000000;
                1:       return 24'h0000AA;
                2:       return 24'h00AA00;
                3:       return 24'h00AAAA;
                4:       return 24'hAA0000;
                5:       return 24'hAA00AA;
                6:       return 24'hAA5500;
                7:       return 24'hAAAAAA;
                8:       return 24'h555555;
                9:       return 24'h5555FF;
                10:      return 24'h55FF55;
                11:      return 24'h55FFFF;
                12:      return 24'hFF5555;
                13:      return 24'hFF55FF;
                14:      return 24'hFFFF55;
                default: return 24'hFFFFFF;
            endcase
        end
        if (n < 32) return {16'h0000, 8'(16 + (n - 16) * 14)};
        if (n < 48) return {8'(16 + (n - 32) * 14), 16'h0000};
        if (n < 64) return {3{8'((n - 48) * 16 + 8)}};
        // six-level cube, blue varying fastest
        k = n - 64;
        return {8'((k / 36) * 51), 8'(((k / 6) % 6) * 51), 8'((k % 6) * 51)};
    endfunction

    // Scan the shadow palette; strict compare keeps the lowest index on ties
    function automatic t_color_match nearest_match(input logic [7:0] r,
                                                   input logic [7:0] g,
                                                   input logic [7:0] b);
        t_color_match                 m;
        logic [pncs_pkg::ENTRY_W-1:0] e;
        int                           best;
        int                           d;
        int                           dr;
        int                           dg;
        int                           db;
        m    = '0;
        best = 256 * 256 * 4;
        for (int j = 0; j < ENTRIES_IN_USE; j++) begin
            e  = palette_shadow[j];
            dr = int'(r) - int'(e[23:16]);
            dg = int'(g) - int'(e[15:8]);
            db = int'(b) - int'(e[7:0]);
            d  = dr * dr + dg * dg + db * db;
            if (d < best) begin
                best    = d;
                m.index = 8'(j);
            end
        end
        m.distance = pncs_pkg::DIST_W'(best);
        return m;
    endfunction

    // Retire results first, then record the request taken at this edge
    always @(posedge i_clk) begin : track
        t_color_match got;
        t_color_match want;
        logic [7:0]   idx;
        logic [7:0]   r;
        logic [7:0]   g;
        logic [7:0]   b;
        if (!i_rst_n) begin
            for (int n = 0; n < pncs_pkg::MAX_ENTRIES; n++) begin
                palette_shadow[n] = (n < ENTRIES_IN_USE) ? power_up_color(n) : '0;
            end
            change_total = '0;
            expected_matches.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.index    = i_m_tdata[7:0];
                got.distance = i_m_tdata[25:8];
                got.count    = i_m_tdata[57:26];
                if (expected_matches.size() == 0) begin
                    $display("%0t: unexpected result, index %0d distance %0d count %0d",
                             $time, got.index, got.distance, got.count);
                    fail_total++;
                end else begin
                    want = expected_matches.pop_front();
                    if (got.index !== want.index) begin
                        $display("%0t: nearest_index expected %0d, actual %0d",
                                 $time, want.index, got.index);
                        fail_total++;
                    end
                    if (got.distance !== want.distance) begin
                        $display("%0t: nearest_distance expected %0d, actual %0d",
                                 $time, want.distance, got.distance);
                        fail_total++;
                    end
                    if (got.count !== want.count) begin
                        $display("%0t: change_count expected %0d, actual %0d",
                                 $time, want.count, got.count);
                        fail_total++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                idx = i_s_tdata[7:0];
                r   = i_s_tdata[15:8];
                g   = i_s_tdata[23:16];
                b   = i_s_tdata[31:24];
                if (i_s_tuser == palette_tb_pkg::FUNC_WRITE) begin
                    // slots past the palette size are dropped untouched
                    if (int'(idx) < ENTRIES_IN_USE) begin
                        palette_shadow[idx] = {r, g, b};
                        change_total        = change_total + 1'b1;
                    end
                    want = '0;
                end else begin
                    want = nearest_match(r, g, b);
                end
                want.count = change_total;
                expected_matches.push_back(want);
            end
        end
        pending_total = expected_matches.size();
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Stimulus for the nearest color search block: directed palette writes and
// lookups, a full palette refill, then mixed random traffic with idle gaps
// and output stalls. Prediction and comparison live in the checker.
// ---------------------------------------------------------------------------
module tb;

    localparam int HOLD_AT_RESULT = 700;
    localparam int HOLD_CYCLES    = 600;
    localparam int DRAIN_CYCLES   = 300;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;    // entry_index, red, green, blue
    logic [0:0]  s_axis_tuser;    // func
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;    // nearest_index, nearest_distance, change_count, pad

    int fail_count;
    int pending;
    int results_taken = 0;
    int writes_sent   = 0;
    int lookups_sent  = 0;
    int steady_left   = 0;
    bit holdoff_done  = 1'b0;

    palette_nearest_color_search dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    palette_match_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 2 ns clock
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Run limit
    initial begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Count result transfers for the receiver's hold-off trigger
    always @(posedge clk) begin
        if (rst_n && m_axis_tvalid && m_axis_tready) results_taken++;
    end

    // Receiver: random ready pattern, one long hold-off while input keeps coming
    initial begin : receiver
        int run;
        int stall;
        m_axis_tready = 1'b0;
        @(negedge clk);
        while (!rst_n) @(negedge clk);
        forever begin
            if (!holdoff_done && results_taken >= HOLD_AT_RESULT) begin
                holdoff_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                              : $urandom_range(1, 12);
            repeat (run) @(negedge clk);
            case ($urandom_range(0, 49))
                0:                   stall = $urandom_range(30, 80);
                1, 2, 3, 4:          stall = $urandom_range(5, 20);
                default:             stall = ($urandom_range(0, 4) < 2) ? 0
                                           : $urandom_range(1, 4);
            endcase
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
        end
    end

    // Gap before the next request: mostly none, a few long, some steady bursts
    function automatic int idle_gap();
        int roll;
        if (steady_left > 0) begin
            steady_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
            steady_left = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    // Color level biased toward extremes and cube steps to provoke ties
    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'($urandom_range(0, 5) * 51);
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Offer one request and hold it until the transfer completes
    task automatic send_item(input palette_tb_pkg::t_pncs_func f, input logic [7:0] idx,
                             input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, g, r, idx};
        s_axis_tuser  <= f;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        @(negedge clk);
        if (f == palette_tb_pkg::FUNC_WRITE) writes_sent++;
        else lookups_sent++;
    endtask

    task automatic send_random(input int lookup_pct);
        logic [7:0] idx;
        case ($urandom_range(0, 9))
            0:       idx = 8'd0;
            1:       idx = 8'd255;
            default: idx = 8'($urandom_range(0, 255));
        endcase
        if ($urandom_range(0, 99) < lookup_pct)
            send_item(palette_tb_pkg::FUNC_LOOKUP, 8'($urandom_range(0, 255)),
                      pick_level(), pick_level(), pick_level());
        else
            send_item(palette_tb_pkg::FUNC_WRITE, idx,
                      pick_level(), pick_level(), pick_level());
    endtask

    // Stop offering and wait until every predicted result has come back
    task automatic wait_all_results();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    initial begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = palette_tb_pkg::FUNC_WRITE;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // power-up palette: exact hits, ties with later duplicates, primaries
        send_item(palette_tb_pkg::FUNC_LOOKUP, 8'd0,   8'd0,   8'd0,   8'd0);
        send_item(palette_tb_pkg::FUNC_LOOKUP, 8'd255, 8'd255, 8'd255, 8'd255);
        send_item(palette_tb_pkg::FUNC_LOOKUP, 8'd7,   8'd255, 8'd0,   8'd0);
        send_item(palette_tb_pkg::FUNC_LOOKUP, 8'd0,   8'd0,   8'd255, 8'd0);
        send_item(palette_tb_pkg::FUNC_LOOKUP, 8'd0,   8'd0,   8'd0,   8'd255);
        send_item(palette_tb_pkg::FUNC_LOOKUP, 8'd0,   8'd128, 8'd128, 8'd128);
        send_item(palette_tb_pkg::FUNC_LOOKUP, 8'd0,   8'd85,  8'd85,  8'd85);
        // writes at both ends of the index range, then lookups that see them
        send_item(palette_tb_pkg::FUNC_WRITE,  8'd0,   8'd255, 8'd255, 8'd255);
        send_item(palette_tb_pkg::FUNC_LOOKUP, 8'd0,   8'd255, 8'd255, 8'd255);
        send_item(palette_tb_pkg::FUNC_WRITE,  8'd255, 8'd0,   8'd0,   8'd0);
        send_item(palette_tb_pkg::FUNC_LOOKUP, 8'd0,   8'd0,   8'd0,   8'd0);
        send_item(palette_tb_pkg::FUNC_WRITE,  8'd255, 8'd1,   8'd2,   8'd3);
        send_item(palette_tb_pkg::FUNC_LOOKUP, 8'd0,   8'd1,   8'd2,   8'd3);
        send_item(palette_tb_pkg::FUNC_WRITE,  8'd128, 8'd255, 8'd255, 8'd255);
        send_item(palette_tb_pkg::FUNC_WRITE,  8'd170, 8'hAA,  8'h55,  8'hAA);
        send_item(palette_tb_pkg::FUNC_WRITE,  8'd85,  8'h55,  8'hAA,  8'h55);
        send_item(palette_tb_pkg::FUNC_LOOKUP, 8'd0,   8'h55,  8'hAA,  8'h55);
        send_item(palette_tb_pkg::FUNC_LOOKUP, 8'd0,   8'hAA,  8'h55,  8'hAA);
        send_item(palette_tb_pkg::FUNC_WRITE,  8'd0,   8'd0,   8'd0,   8'd0);
        send_item(palette_tb_pkg::FUNC_LOOKUP, 8'd0,   8'd1,   8'd1,   8'd1);
        wait_all_results();

        // mixed traffic on the power-up palette
        repeat (300) send_random(50);
        wait_all_results();

        // repaint every slot black, then probe for the largest distance
        for (int n = 0; n < 256; n++) begin
            send_item(palette_tb_pkg::FUNC_WRITE, 8'(n), 8'd0, 8'd0, 8'd0);
        end
        send_item(palette_tb_pkg::FUNC_LOOKUP, 8'd0, 8'd255, 8'd255, 8'd255);
        send_item(palette_tb_pkg::FUNC_LOOKUP, 8'd0, 8'd255, 8'd0,   8'd0);
        send_item(palette_tb_pkg::FUNC_LOOKUP, 8'd0, 8'd0,   8'd0,   8'd0);
        send_item(palette_tb_pkg::FUNC_LOOKUP, 8'd0, pick_level(), pick_level(),
                  pick_level());

        // random repaint over the black palette; the output hold-off lands here
        repeat (570) send_random(50);
        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d palette writes and %0d nearest-color lookups, %0d results",
                 writes_sent, lookups_sent, results_taken);
        $display("Included tie cases, a full black refill, a long output stall and gaps");
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
